/* hw/rtl/upd_pkg.sv */
// Shared constants, types and the hex digit function for the URL percent decoder.
`default_nettype none

package upd_pkg;

    // Longest decoded path, and the counter width needed to hold it
    localparam int MAX_PATH_LEN = 4096;
    localparam int CNT_W        = $clog2(MAX_PATH_LEN + 1);

    // Fixed field widths of the words
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 13;
    localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    // Result queue depth; a decode step pushes at most two results
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int PUSH_MAX   = 2;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h61;
    localparam logic [BYTE_W-1:0] CH_F     = 8'h66;
    localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;
    localparam logic [BYTE_W-1:0] HEX_TEN  = 8'd10;

    // Hex digit value, with bit 4 set for a character that is no hex digit
    localparam logic [4:0] HEX_BAD = 5'd16;

    // Result kinds
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Escape phase
    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2
    } t_phase;

    // One result word
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic              error;
        logic [LEN_W-1:0]  decoded_len;
        logic [LEN_W-1:0]  ext_len;
        logic              last;
    } t_res;

    // Results handed from the decode stage to the result queue, in order
    typedef struct packed {
        logic [1:0] num;
        t_res       r0;
        t_res       r1;
    } t_push;

    function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] ch);
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] v;
        c = ch | CASE_BIT;
        v = '0;
        if (ch >= CH_0 && ch <= CH_9) begin
            v = ch - CH_0;
            return v[4:0];
        end else if (c >= CH_A && c <= CH_F) begin
            v = c - CH_A + HEX_TEN;
            return v[4:0];
        end
        return HEX_BAD;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/upd_in_if.sv */
// Input channel: one raw path byte per word.
`default_nettype none

interface upd_in_if;
    logic                        valid;
    logic                        ready;
    logic [upd_pkg::BYTE_W-1:0]  in_byte;
    logic                        in_last;
    logic [upd_pkg::LEN_W-1:0]   ext_window;

    modport source (output valid, output in_byte, output in_last, output ext_window,
                    input ready);
    modport sink   (input valid, input in_byte, input in_last, input ext_window,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/upd_out_if.sv */
// Output channel: a decoded byte or an end-of-path summary per word.
`default_nettype none

interface upd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [upd_pkg::BYTE_W-1:0]  data_byte;
    logic                        error;
    logic [upd_pkg::LEN_W-1:0]   decoded_len;
    logic [upd_pkg::LEN_W-1:0]   ext_len;
    logic                        last;

    modport source (output valid, output kind, output data_byte, output error,
                    output decoded_len, output ext_len, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input error,
                    input decoded_len, input ext_len, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/upd_decode.sv */
// Input register and single-pass percent decode with path bookkeeping.
`default_nettype none

module upd_decode (
    input  wire              i_clk,
    input  wire              i_rst_n,
    upd_in_if.sink           i_in,
    input  wire              i_room,
    output upd_pkg::t_push   o_push
);

    // Input register
    logic                              r_in_valid;
    logic [upd_pkg::BYTE_W-1:0]        r_in_byte;
    logic                              r_in_last;
    logic [upd_pkg::LEN_W-1:0]         r_in_win;

    // Path state
    upd_pkg::t_phase                   r_phase, n_phase;
    logic [3:0]                        r_nib, n_nib;
    logic [upd_pkg::CNT_W-1:0]         r_count, n_count;
    logic [upd_pkg::CNT_W-1:0]         r_dot, n_dot;
    logic                              r_seen, n_seen;
    logic                              r_err, n_err;

    logic                              fire;
    logic                              accept;
    logic [4:0]                        hv;
    logic                              want;
    logic                              dec_err;
    logic [upd_pkg::BYTE_W-1:0]        dec_byte;
    logic                              ovf;
    logic                              emit;
    logic                              fin_err;
    logic [upd_pkg::CMP_W-1:0]         cnt_w;
    logic [upd_pkg::CMP_W-1:0]         dot_w;
    logic [upd_pkg::CMP_W-1:0]         win_w;
    logic [upd_pkg::CMP_W-1:0]         span;
    logic [upd_pkg::CMP_W-1:0]         elen;
    upd_pkg::t_res                     res_byte;
    upd_pkg::t_res                     res_sum;

    assign fire       = r_in_valid && i_room;
    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || fire;
    assign hv         = upd_pkg::hex_value(r_in_byte);

    // Hold the incoming word until the decode step takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.in_last;
            r_in_win  <= i_in.ext_window;
        end
    end

    // Escape phase next state
    always_comb begin
        n_phase = r_phase;
        n_nib   = r_nib;
        if (!r_err) begin
            unique case (r_phase)
                upd_pkg::PH_HIGH: begin
                    if (!hv[4]) begin
                        n_nib   = hv[3:0];
                        n_phase = upd_pkg::PH_LOW;
                    end
                end
                upd_pkg::PH_LOW: begin
                    if (!hv[4]) begin
                        n_phase = upd_pkg::PH_PLAIN;
                    end
                end
                default: begin
                    n_phase = (r_in_byte == upd_pkg::CH_PCT) ? upd_pkg::PH_HIGH
                                                             : upd_pkg::PH_PLAIN;
                end
            endcase
        end
    end

    // Escape phase outputs: byte to emit, bad digit
    always_comb begin
        want     = 1'b0;
        dec_err  = 1'b0;
        dec_byte = r_in_byte;
        if (!r_err) begin
            unique case (r_phase)
                upd_pkg::PH_HIGH: begin
                    dec_err = hv[4];
                end
                upd_pkg::PH_LOW: begin
                    dec_err  = hv[4];
                    want     = !hv[4];
                    dec_byte = {r_nib, hv[3:0]};
                end
                default: begin
                    want = (r_in_byte != upd_pkg::CH_PCT);
                end
            endcase
        end
    end

    // Count, dot tracking and overflow
    always_comb begin
        ovf     = want && (r_count >= upd_pkg::CNT_W'(upd_pkg::MAX_PATH_LEN));
        emit    = want && !ovf;
        n_err   = r_err || dec_err || ovf;
        n_count = r_count;
        n_dot   = r_dot;
        n_seen  = r_seen;
        if (emit) begin
            n_count = r_count + 1'b1;
            if (dec_byte == upd_pkg::CH_DOT) begin
                n_dot  = r_count;
                n_seen = 1'b1;
            end
        end
    end

    // Summary: clamp the window to the path and test the last dot against it
    always_comb begin
        fin_err = n_err || (n_phase != upd_pkg::PH_PLAIN);
        cnt_w   = upd_pkg::CMP_W'(n_count);
        dot_w   = upd_pkg::CMP_W'(n_dot);
        win_w   = upd_pkg::CMP_W'(r_in_win);
        span    = (win_w > cnt_w) ? cnt_w : win_w;
        elen    = '0;
        if (!fin_err && (win_w != '0) && n_seen && (dot_w >= cnt_w - span)) begin
            elen = cnt_w - dot_w;
        end
    end

    // Build the results in output order
    always_comb begin
        res_byte             = '0;
        res_byte.kind        = upd_pkg::KIND_BYTE;
        res_byte.data_byte   = dec_byte;

        res_sum              = '0;
        res_sum.kind         = upd_pkg::KIND_SUMMARY;
        res_sum.error        = fin_err;
        res_sum.decoded_len  = fin_err ? '0 : upd_pkg::LEN_W'(n_count);
        res_sum.ext_len      = upd_pkg::LEN_W'(elen);
        res_sum.last         = 1'b1;

        o_push     = '0;
        o_push.r1  = res_sum;
        if (fire) begin
            if (emit) begin
                o_push.r0  = res_byte;
                o_push.num = r_in_last ? 2'd2 : 2'd1;
            end else if (r_in_last) begin
                o_push.r0  = res_sum;
                o_push.num = 2'd1;
            end
        end
    end

    // Advance path state; drop it all back to reset after the summary
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= upd_pkg::PH_PLAIN;
            r_nib   <= '0;
            r_count <= '0;
            r_dot   <= '0;
            r_seen  <= 1'b0;
            r_err   <= 1'b0;
        end else if (fire) begin
            if (r_in_last) begin
                r_phase <= upd_pkg::PH_PLAIN;
                r_nib   <= '0;
                r_count <= '0;
                r_dot   <= '0;
                r_seen  <= 1'b0;
                r_err   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_nib   <= n_nib;
                r_count <= n_count;
                r_dot   <= n_dot;
                r_seen  <= n_seen;
                r_err   <= n_err;
            end
        end
    end

    // The path ends with clean state
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_last |=> r_count == '0 && !r_err && r_phase == upd_pkg::PH_PLAIN)
        else $error("path state not cleared after summary");

    // No byte leaves once the path is in error
    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_err |-> !emit)
        else $error("byte emitted after error");

    // Count never runs past the path limit
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= upd_pkg::CNT_W'(upd_pkg::MAX_PATH_LEN))
        else $error("decoded count beyond limit");

endmodule

`default_nettype wire

/* hw/rtl/upd_res_fifo.sv */
// Small result queue that takes up to two words per cycle and gives one.
`default_nettype none

module upd_res_fifo (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire upd_pkg::t_push    i_push,
    output logic                   o_room,
    upd_out_if.source              o_out
);

    upd_pkg::t_res                   r_mem [upd_pkg::FIFO_DEPTH];
    logic [upd_pkg::FIFO_AW-1:0]     r_wr;
    logic [upd_pkg::FIFO_AW-1:0]     r_rd;
    logic [upd_pkg::FIFO_CW-1:0]     r_cnt;
    logic [upd_pkg::FIFO_AW-1:0]     wr1;
    logic                            pop;
    upd_pkg::t_res                   head;

    assign wr1    = r_wr + 1'b1;
    assign pop    = o_out.valid && o_out.ready;
    assign o_room = r_cnt <= upd_pkg::FIFO_CW'(upd_pkg::FIFO_DEPTH - upd_pkg::PUSH_MAX);
    assign head   = r_mem[r_rd];

    // Present the head word
    assign o_out.valid       = r_cnt != '0;
    assign o_out.kind        = head.kind;
    assign o_out.data_byte   = head.data_byte;
    assign o_out.error       = head.error;
    assign o_out.decoded_len = head.decoded_len;
    assign o_out.ext_len     = head.ext_len;
    assign o_out.last        = head.last;

    // Write pushed words in order
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr1] <= i_push.r1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + upd_pkg::FIFO_AW'(i_push.num);
            r_rd  <= r_rd + upd_pkg::FIFO_AW'(pop);
            r_cnt <= r_cnt + upd_pkg::FIFO_CW'(i_push.num) - upd_pkg::FIFO_CW'(pop);
        end
    end

    // Pushes only land when the queue had room for them
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.num != 2'd0 |-> o_room)
        else $error("result queue overrun");

    // Count stays within depth
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= upd_pkg::FIFO_CW'(upd_pkg::FIFO_DEPTH))
        else $error("result queue count beyond depth");

    // A waiting head word holds until taken
    a_hold_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(head))
        else $error("head word changed while waiting");

endmodule

`default_nettype wire

/* hw/rtl/url_percent_decoder.sv */
// Top level of the streaming URL percent decoder.
//
// Raw path bytes enter one word per cycle on i_in while ready is high;
// '%' plus two hex digits becomes one byte, other bytes pass through, and
// each decoded byte leaves as a kind 0 word on o_out. The word marked
// in_last is followed by a kind 1 summary with the error flag, decoded
// length and extension length (read from ext_window on that word). A bad
// digit, an escape cut off at the end or a path past 4096 decoded bytes
// sets the error and silences byte output until the summary. An input word
// is held in the input register, decoded from it once the result queue has
// room, and written to a four-word result queue, from whose head results
// leave. The block takes one word per cycle while results are drained; a
// last word that yields both a byte and a summary pushes two words at once,
// which the queue absorbs.
`default_nettype none

module url_percent_decoder (
    input  wire          i_clk,
    input  wire          i_rst_n,
    upd_in_if.sink       i_in,
    upd_out_if.source    o_out
);

    upd_pkg::t_push push;
    logic           room;

    upd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_room  (room),
        .o_push  (push)
    );

    upd_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

/* tb/upd_result_checker.sv */
// Checker for the URL percent decoder: predicts result words and compares them.
`timescale 1ns / 1ps

module upd_result_checker (
    input  wire  i_clk,
    input  wire  i_rst_n,
    upd_in_if    i_in,
    upd_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    import upd_pkg::*;

    // Result words still owed by the block, oldest first
    t_res expected_words[$];

    // Predicted decoder state for the path in progress
    t_phase     esc_phase;
    logic [3:0] hi_nib;
    int         dec_count;
    int         dot_pos;
    logic       have_dot;
    logic       sticky_err;
    int         fails;

    // Value of a hex digit in either case, HEX_BAD for anything else
    function automatic logic [4:0] digit_of(input logic [BYTE_W-1:0] ch);
        logic [BYTE_W-1:0] lc;
        lc = ch | CASE_BIT;
        if (ch >= CH_0 && ch <= CH_9)
            return {1'b0, ch[3:0]};
        if (lc >= CH_A && lc <= CH_F)
            return {1'b0, lc[3:0] + 4'd9};
        return HEX_BAD;
    endfunction

    function automatic t_res make_word(input logic kind, input logic [BYTE_W-1:0] data,
                                       input logic err, input int dlen, input int elen,
                                       input logic last);
        t_res r;
        r.kind        = kind;
        r.data_byte   = data;
        r.error       = err;
        r.decoded_len = dlen[LEN_W-1:0];
        r.ext_len     = elen[LEN_W-1:0];
        r.last        = last;
        return r;
    endfunction

    task automatic clear_path();
        esc_phase  = PH_PLAIN;
        hi_nib     = '0;
        dec_count  = 0;
        dot_pos    = 0;
        have_dot   = 1'b0;
        sticky_err = 1'b0;
    endtask

    // Emit one decoded byte, or flag the path as too long
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        if (dec_count >= MAX_PATH_LEN) begin
            sticky_err = 1'b1;
        end else begin
            if (b == CH_DOT) begin
                dot_pos  = dec_count;
                have_dot = 1'b1;
            end
            dec_count++;
            expected_words.push_back(make_word(KIND_BYTE, b, 1'b0, 0, 0, 1'b0));
        end
    endtask

    // Advance the prediction by one accepted input word
    task automatic predict_word(input logic [BYTE_W-1:0] b, input logic l,
                                input logic [LEN_W-1:0] window);
        logic [4:0] d;
        int         win;
        int         span;
        int         dlen;
        int         elen;
        win = window;
        if (!sticky_err) begin
            case (esc_phase)
                PH_HIGH: begin
                    d = digit_of(b);
                    if (d == HEX_BAD) begin
                        sticky_err = 1'b1;
                    end else begin
                        hi_nib    = d[3:0];
                        esc_phase = PH_LOW;
                    end
                end
                PH_LOW: begin
                    d = digit_of(b);
                    if (d == HEX_BAD) begin
                        sticky_err = 1'b1;
                    end else begin
                        esc_phase = PH_PLAIN;
                        push_byte({hi_nib, d[3:0]});
                    end
                end
                default: begin
                    esc_phase = PH_PLAIN;
                    if (b == CH_PCT)
                        esc_phase = PH_HIGH;
                    else
                        push_byte(b);
                end
            endcase
        end
        // Close the path with its summary word
        if (l) begin
            dlen = 0;
            elen = 0;
            if (!sticky_err && esc_phase != PH_PLAIN)
                sticky_err = 1'b1;
            if (!sticky_err) begin
                dlen = dec_count;
                if (win != 0 && have_dot) begin
                    span = (win > dec_count) ? dec_count : win;
                    if (dot_pos >= dec_count - span)
                        elen = dec_count - dot_pos;
                end
            end
            expected_words.push_back(make_word(KIND_SUMMARY, '0, sticky_err, dlen, elen, 1'b1));
            clear_path();
        end
    endtask

    // Compare outgoing words first, then predict from the incoming word
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            clear_path();
            expected_words.delete();
            fails = 0;
        end else begin
            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) begin
                got = make_word(i_out.kind, i_out.data_byte, i_out.error, i_out.decoded_len,
                                i_out.ext_len, i_out.last);
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual kind=%0d byte=%02h",
                             $time, got.kind, got.data_byte,
                             " err=%0d len=%0d ext=%0d last=%0d",
                             got.error, got.decoded_len, got.ext_len, got.last);
                    fails++;
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        $display("%0t: word mismatch: expected kind=%0d byte=%02h err=%0d",
                                 $time, want.kind, want.data_byte, want.error,
                                 " len=%0d ext=%0d last=%0d, actual kind=%0d byte=%02h",
                                 want.decoded_len, want.ext_len, want.last,
                                 got.kind, got.data_byte,
                                 " err=%0d len=%0d ext=%0d last=%0d",
                                 got.error, got.decoded_len, got.ext_len, got.last);
                        fails++;
                    end
                end
            end
            if (i_in.valid === 1'b1 && i_in.ready === 1'b1)
                predict_word(i_in.in_byte, i_in.in_last, i_in.ext_window);
        end
        o_fail_count <= fails;
        o_pending    <= expected_words.size();
    end

endmodule

/* tb/tb_url_percent_decoder.sv */
// Testbench top for the URL percent decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_url_percent_decoder;
    import upd_pkg::*;

    localparam int RANDOM_WORDS = 1600;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_OFF     = 400;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [LEN_W-1:0] WINDOW_MAX = LEN_W'(MAX_PATH_LEN);

    logic i_clk;
    logic i_rst_n;

    upd_in_if  in_ch ();
    upd_out_if out_ch ();

    int              fail_count;
    int              pending;
    logic [BYTE_W-1:0] path_q[$];
    int              words_sent;
    int              idle_cycles;
    bit              steady_sender;

    url_percent_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    upd_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Any byte but the escape character
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(0, 255)); while (b == CH_PCT);
        return b;
    endfunction

    // Hex digit character, letters in random case
    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] v);
        logic [BYTE_W-1:0] c;
        if (v < 4'd10) begin
            c = CH_0 + BYTE_W'(v);
        end else begin
            c = CH_A + BYTE_W'(v - 4'd10);
            if ($urandom_range(0, 1) == 1)
                c = c & ~CASE_BIT;
        end
        return c;
    endfunction

    // Byte outside every hex digit range
    function automatic logic [BYTE_W-1:0] bad_char();
        case ($urandom_range(0, 3))
            0: return BYTE_W'($urandom_range(8'h00, 8'h2F));
            1: return BYTE_W'($urandom_range(8'h3A, 8'h40));
            2: return BYTE_W'($urandom_range(8'h47, 8'h60));
            default: return BYTE_W'($urandom_range(8'h67, 8'hFF));
        endcase
    endfunction

    // Offer one word and hold it until accepted
    task automatic send_word(input logic [BYTE_W-1:0] b, input logic l,
                             input logic [LEN_W-1:0] w);
        int gap;
        gap = steady_sender ? 0 : idle_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.in_byte    <= b;
        in_ch.in_last    <= l;
        in_ch.ext_window <= w;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        words_sent++;
    endtask

    // Send the queued path; the window only matters on the last word
    task automatic send_path(input logic [LEN_W-1:0] window);
        logic [LEN_W-1:0] w;
        foreach (path_q[i]) begin
            w = (i == path_q.size() - 1) ? window : LEN_W'($urandom_range(0, MAX_PATH_LEN));
            send_word(path_q[i], i == path_q.size() - 1, w);
        end
    endtask

    // Path at the length limit, or just past it
    task automatic send_long_path(input bit overflow);
        int n;
        n = overflow ? MAX_PATH_LEN + 3 : MAX_PATH_LEN;
        path_q.delete();
        repeat (n) path_q.push_back(plain_byte());
        path_q[n - 6] = CH_DOT;
        send_path(overflow ? LEN_W'($urandom_range(0, MAX_PATH_LEN)) : WINDOW_MAX);
    endtask

    // Mostly well-formed paths with random content, some broken, some noise
    task automatic build_random_path(output logic [LEN_W-1:0] window);
        int                target;
        int                style;
        logic [BYTE_W-1:0] v;
        path_q.delete();
        target = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        style  = $urandom_range(0, 9);
        if (style == 0) begin
            repeat (target) begin
                if ($urandom_range(0, 5) == 0)
                    path_q.push_back(CH_PCT);
                else
                    path_q.push_back(BYTE_W'($urandom_range(0, 255)));
            end
        end else begin
            while (path_q.size() < target) begin
                case ($urandom_range(0, 7))
                    0, 1: begin
                        v = ($urandom_range(0, 5) == 0) ? CH_DOT : BYTE_W'($urandom_range(0, 255));
                        path_q.push_back(CH_PCT);
                        path_q.push_back(hex_char(v[7:4]));
                        path_q.push_back(hex_char(v[3:0]));
                    end
                    2: path_q.push_back(CH_DOT);
                    default: path_q.push_back(plain_byte());
                endcase
            end
            // Break the path: cut an escape off or spoil a digit
            if (style == 1) begin
                path_q.push_back(CH_PCT);
                case ($urandom_range(0, 2))
                    0: begin
                        if ($urandom_range(0, 1) == 1)
                            path_q.push_back(hex_char(4'($urandom_range(0, 15))));
                    end
                    1: begin
                        path_q.push_back(bad_char());
                        repeat ($urandom_range(0, 5)) path_q.push_back(plain_byte());
                    end
                    default: begin
                        path_q.push_back(hex_char(4'($urandom_range(0, 15))));
                        path_q.push_back(bad_char());
                        repeat ($urandom_range(0, 5)) path_q.push_back(plain_byte());
                    end
                endcase
            end
        end
        case ($urandom_range(0, 4))
            0: window = '0;
            1: window = WINDOW_MAX;
            2, 3: window = LEN_W'($urandom_range(1, path_q.size() + 2));
            default: window = LEN_W'($urandom_range(0, MAX_PATH_LEN));
        endcase
    endtask

    // Stimulus and verdict
    initial begin
        int               rand_count;
        int               path_no;
        logic [LEN_W-1:0] window;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.in_byte    <= '0;
        in_ch.in_last    <= 1'b0;
        in_ch.ext_window <= '0;
        words_sent    = 0;
        steady_sender = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Byte extremes and a dot right at the end
        path_q = '{8'h00, 8'hFF, CH_DOT};
        send_path(LEN_W'(1));
        // Escapes with upper and lower case digits
        path_q = '{CH_PCT, 8'h34, 8'h41, CH_PCT, 8'h66, 8'h46};
        send_path('0);
        // Escaped dot, window larger than the path
        path_q = '{CH_PCT, 8'h32, 8'h65, 8'h78};
        send_path(WINDOW_MAX);
        // Dot outside the window
        path_q = '{CH_DOT, 8'h62, 8'h63};
        send_path(LEN_W'(1));
        // Bad high digit, later bytes ignored
        path_q = '{CH_PCT, 8'h47, 8'h78};
        send_path(LEN_W'(3));
        // Bad low digit
        path_q = '{CH_PCT, 8'h34, 8'h7A};
        send_path(LEN_W'(3));
        // Escape cut off by the end of the path
        path_q = '{CH_PCT};
        send_path(WINDOW_MAX);

        // Random paths, with one full-length and one overlong path among them
        rand_count = 0;
        path_no    = 0;
        while (rand_count < RANDOM_WORDS) begin
            steady_sender = ($urandom_range(0, 4) == 0);
            if (path_no == 30)
                send_long_path(1'b0);
            if (path_no == 60)
                send_long_path(1'b1);
            build_random_path(window);
            rand_count += path_q.size();
            send_path(window);
            path_no++;
        end
        in_ch.valid <= 1'b0;

        // Drain outstanding words, then keep watching for stray words before the verdict
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver: random stalls, bursts of readiness, and one long hold-off
    initial begin
        bit held;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (2) @(posedge i_clk);
        forever begin
            if (!held && words_sent >= HOLD_AFTER) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                    : $urandom_range(1, 20))
                    @(posedge i_clk);
                if (idle_len() > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (idle_len() + 1) @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                     (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule
